[src/bss_pkg.sv]
// Package for the bounded sequence store: sizes, operation codes and the
// request, result and memory-port structs shared by the controller and top.
// No dependencies.
package bss_pkg;

	localparam int CAPACITY = 64;
	localparam int DATA_W   = 32;
	localparam int POS_W    = 8;
	localparam int FUNC_W   = 2;
	localparam int ADDR_W   = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);

	localparam logic [FUNC_W-1:0] FUNC_PUSH_FRONT = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_APPEND     = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_REMOVE     = 2'd2;

	typedef struct packed {
		logic [FUNC_W-1:0]        func;
		logic signed [DATA_W-1:0] value;
		logic [POS_W-1:0]         position;
	} req_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] element;
		logic                     last;
		logic                     empty_res;
		logic                     rejected;
	} res_t;

	typedef struct packed {
		logic              re;
		logic [ADDR_W-1:0] raddr;
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [DATA_W-1:0] wdata;
	} mem_req_t;

endpackage

[src/bss_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered
// read data. No package dependency.
module bss_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 32,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write and read the array, read data registered
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[src/bss_ctrl.sv]
// Sequencer of the bounded sequence store: decodes a request, moves stored
// elements through the RAM one per cycle, then reads out the whole sequence.
// Depends on bss_pkg.
module bss_ctrl (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  bss_pkg::req_t             req,
	output logic                      busy,
	output logic                      strobe,
	output bss_pkg::res_t             res,
	output bss_pkg::mem_req_t         mem,
	input  logic [bss_pkg::DATA_W-1:0] rdata
);

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_SHIFT = 4'b0010,
		S_FILL  = 4'b0100,
		S_DUMP  = 4'b1000
	} state_t;

	state_t state_q, state_d;
	logic [bss_pkg::CNT_W-1:0]  count_q, count_d;
	logic                       issuing_q, issuing_d;
	logic [bss_pkg::ADDR_W-1:0] idx_q, idx_d;
	logic [bss_pkg::ADDR_W-1:0] end_q, end_d;
	logic                       up_q, up_d;
	logic [bss_pkg::ADDR_W-1:0] fill_addr_q, fill_d;
	bss_pkg::req_t              req_q, req_d;
	logic                       rej_q, rej_d;
	logic                       rd_vld_s1;
	logic [bss_pkg::ADDR_W-1:0] rd_addr_s1;

	logic [bss_pkg::CNT_W-1:0]  cnt_m1;
	logic [bss_pkg::ADDR_W-1:0] last_idx;
	logic [bss_pkg::ADDR_W-1:0] pos_lo;
	logic                       full;
	logic                       pos_hit;

	// derive count-related terms
	assign cnt_m1   = count_q - bss_pkg::CNT_W'(1);
	assign last_idx = cnt_m1[bss_pkg::ADDR_W-1:0];
	assign full     = (count_q >= bss_pkg::CNT_W'(bss_pkg::CAPACITY));
	assign pos_hit  = (req.position < bss_pkg::POS_W'(count_q));
	assign pos_lo   = req.position[bss_pkg::ADDR_W-1:0];
	assign busy     = (state_q != S_IDLE);

	// decode, shift, fill and dump sequencing
	always_comb begin
		state_d   = state_q;
		count_d   = count_q;
		issuing_d = issuing_q;
		idx_d     = idx_q;
		end_d     = end_q;
		up_d      = up_q;
		fill_d    = fill_addr_q;
		req_d     = req_q;
		rej_d     = rej_q;
		mem       = '0;
		strobe    = 1'b0;
		res       = '0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					req_d     = req;
					rej_d     = 1'b0;
					idx_d     = '0;
					issuing_d = 1'b1;
					state_d   = S_DUMP;
					case (req.func)
						bss_pkg::FUNC_PUSH_FRONT: begin
							if (full) begin
								rej_d = 1'b1;
							end else if (count_q == '0) begin
								state_d = S_FILL;
								fill_d  = '0;
							end else begin
								state_d = S_SHIFT;
								up_d    = 1'b1;
								idx_d   = last_idx;
								end_d   = '0;
							end
						end
						bss_pkg::FUNC_APPEND: begin
							if (full) begin
								rej_d = 1'b1;
							end else begin
								state_d = S_FILL;
								fill_d  = count_q[bss_pkg::ADDR_W-1:0];
							end
						end
						bss_pkg::FUNC_REMOVE: begin
							if (pos_hit) begin
								if (pos_lo == last_idx) begin
									count_d = cnt_m1;
								end else begin
									state_d = S_SHIFT;
									up_d    = 1'b0;
									idx_d   = pos_lo + bss_pkg::ADDR_W'(1);
									end_d   = last_idx;
								end
							end
						end
						default: ;
					endcase
				end
			end
			S_SHIFT: begin
				// read one element a cycle, write it one slot over once its read data returns
				mem.re    = issuing_q;
				mem.raddr = idx_q;
				if (issuing_q) begin
					if (idx_q == end_q) begin
						issuing_d = 1'b0;
					end else begin
						idx_d = up_q ? idx_q - bss_pkg::ADDR_W'(1)
						             : idx_q + bss_pkg::ADDR_W'(1);
					end
				end
				if (rd_vld_s1) begin
					mem.we    = 1'b1;
					mem.waddr = up_q ? rd_addr_s1 + bss_pkg::ADDR_W'(1)
					                 : rd_addr_s1 - bss_pkg::ADDR_W'(1);
					mem.wdata = rdata;
				end
				if (!issuing_q && rd_vld_s1) begin
					if (up_q) begin
						state_d = S_FILL;
						fill_d  = '0;
					end else begin
						count_d   = cnt_m1;
						state_d   = S_DUMP;
						idx_d     = '0;
						issuing_d = 1'b1;
					end
				end
			end
			S_FILL: begin
				// drop the new value into its slot
				mem.we    = 1'b1;
				mem.waddr = fill_addr_q;
				mem.wdata = req_q.value;
				count_d   = count_q + bss_pkg::CNT_W'(1);
				state_d   = S_DUMP;
				idx_d     = '0;
				issuing_d = 1'b1;
			end
			S_DUMP: begin
				if (count_q == '0) begin
					strobe        = 1'b1;
					res.last      = 1'b1;
					res.empty_res = 1'b1;
					res.rejected  = rej_q;
					state_d       = S_IDLE;
				end else begin
					mem.re    = issuing_q;
					mem.raddr = idx_q;
					if (issuing_q) begin
						if (idx_q == last_idx) begin
							issuing_d = 1'b0;
						end else begin
							idx_d = idx_q + bss_pkg::ADDR_W'(1);
						end
					end
					if (rd_vld_s1) begin
						strobe       = 1'b1;
						res.element  = rdata;
						res.last     = (rd_addr_s1 == last_idx);
						res.rejected = rej_q;
						if (rd_addr_s1 == last_idx) begin
							state_d = S_IDLE;
						end
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			count_q   <= '0;
			issuing_q <= 1'b0;
			rd_vld_s1 <= 1'b0;
		end else begin
			state_q   <= state_d;
			count_q   <= count_d;
			issuing_q <= issuing_d;
			rd_vld_s1 <= mem.re;
		end
	end

	// payload and address registers
	always_ff @(posedge clk) begin
		idx_q       <= idx_d;
		end_q       <= end_d;
		up_q        <= up_d;
		fill_addr_q <= fill_d;
		req_q       <= req_d;
		rej_q       <= rej_d;
		rd_addr_s1  <= mem.raddr;
	end

	// a move never reads the slot it writes in the same cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		(mem.we && mem.re) |-> (mem.waddr != mem.raddr))
		else $error("read and write hit the same entry");

	// the count never passes capacity
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= bss_pkg::CNT_W'(bss_pkg::CAPACITY))
		else $error("entry count beyond capacity");

	// the count moves by at most one per cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == $past(count_q)) ||
		(count_q == $past(count_q) + bss_pkg::CNT_W'(1)) ||
		(count_q == $past(count_q) - bss_pkg::CNT_W'(1)))
		else $error("entry count jumped");

	// the final result of a dump frees the block
	assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && res.last) |=> !busy)
		else $error("still busy after last result");

	// an accepted request always produces work
	assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("request accepted but block idle");

endmodule

[src/bounded_sequence_store_unit.sv]
// Bounded sequence store: up to CAPACITY signed values held in one RAM.
// Busy after accept: a front insert or a remove first shifts the elements it
// displaces one slot over, an insert that fits then writes its value, and the
// sequence streams out, one result per cycle (one empty result if empty).
// Reset clears the count, so the store reads as empty; RAM is not cleared.
// Results carry a one-cycle strobe; the receiver cannot stall.
module bounded_sequence_store_unit (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  bss_pkg::req_t req,
	output logic          strobe,
	output bss_pkg::res_t res
);

	bss_pkg::mem_req_t          mem;
	logic [bss_pkg::DATA_W-1:0] rdata;

	// sequencer
	bss_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.req    (req),
		.busy   (busy),
		.strobe (strobe),
		.res    (res),
		.mem    (mem),
		.rdata  (rdata)
	);

	// element storage
	bss_ram #(
		.DEPTH (bss_pkg::CAPACITY),
		.WIDTH (bss_pkg::DATA_W)
	) u_ram (
		.clk   (clk),
		.we    (mem.we),
		.waddr (mem.waddr),
		.wdata (mem.wdata),
		.re    (mem.re),
		.raddr (mem.raddr),
		.rdata (rdata)
	);

endmodule

[tb/tb_top.sv]
// Testbench for bounded_sequence_store_unit: directed and random requests,
// each checked against a queue-based model of the stored sequence.
// Depends on bss_pkg and the bounded_sequence_store_unit RTL.
`timescale 1ns / 100ps

module tb_top;
	import bss_pkg::*;

	localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
	localparam int DRAIN_CYCLES = 2 * CAPACITY + 20;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	req_t req = '0;
	logic busy;
	logic strobe;
	res_t res;

	// model of the stored sequence, front at index 0
	logic signed [DATA_W-1:0] seq_model[$];
	req_t req_pending_q[$];
	res_t dump_expect_q[$];

	int gap_left = 0;
	int burst_left = 0;
	int accepted_n = 0;
	int checked_n = 0;
	int reject_n = 0;
	int peak_depth = 0;
	int err_n = 0;
	res_t exp_r;

	bounded_sequence_store_unit u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req(req),
		.strobe(strobe),
		.res(res)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// apply one accepted request to the model and queue the dump it causes
	task automatic apply_request(input req_t r);
		logic rej;
		res_t e;
		int i;
		rej = 1'b0;
		case (r.func)
			FUNC_PUSH_FRONT, FUNC_APPEND: begin
				if (seq_model.size() >= CAPACITY) begin
					rej = 1'b1;
					reject_n++;
				end else if (r.func == FUNC_PUSH_FRONT) begin
					seq_model.push_front(r.value);
				end else begin
					seq_model.push_back(r.value);
				end
			end
			FUNC_REMOVE: begin
				if (r.position < seq_model.size())
					seq_model.delete(r.position);
			end
			default: ;
		endcase
		if (seq_model.size() > peak_depth)
			peak_depth = seq_model.size();
		if (seq_model.size() == 0) begin
			e = '{element: '0, last: 1'b1, empty_res: 1'b1, rejected: rej};
			dump_expect_q.push_back(e);
		end else begin
			for (i = 0; i < seq_model.size(); i++) begin
				e = '{element: seq_model[i], last: (i == seq_model.size() - 1),
					empty_res: 1'b0, rejected: rej};
				dump_expect_q.push_back(e);
			end
		end
	endtask

	// idle length after a request: mostly none or short, a few long,
	// with occasional runs of back-to-back requests
	function automatic int pick_gap();
		int roll;
		if (burst_left > 0) begin
			burst_left--;
			return 0;
		end
		roll = $urandom_range(0, 99);
		if (roll < 8) begin
			burst_left = $urandom_range(6, 20);
			return 0;
		end
		if (roll < 40) return 0;
		if (roll < 85) return $urandom_range(1, 3);
		if (roll < 96) return $urandom_range(4, 12);
		return $urandom_range(20, 80);
	endfunction

	// random request; ins_pct sets the share of inserts
	function automatic req_t random_request(input int ins_pct);
		req_t r;
		int roll;
		int n;
		n = seq_model.size();
		roll = $urandom_range(0, 99);
		r.position = POS_W'($urandom);
		if ($urandom_range(0, 9) == 0) begin
			case ($urandom_range(0, 3))
				0: r.value = 32'sh8000_0000;
				1: r.value = 32'sh7FFF_FFFF;
				2: r.value = '0;
				default: r.value = '1;
			endcase
		end else begin
			r.value = $urandom;
		end
		if (roll < ins_pct) begin
			r.func = $urandom_range(0, 1) ? FUNC_APPEND : FUNC_PUSH_FRONT;
		end else if (roll < 95) begin
			r.func = FUNC_REMOVE;
			if (n > 0 && $urandom_range(0, 4) != 0)
				r.position = POS_W'($urandom_range(0, n - 1));
			else
				r.position = POS_W'($urandom_range(n, 255));
		end else begin
			r.func = FUNC_UNUSED;
		end
		return r;
	endfunction

	// hand one request to the driver and wait until the block takes it
	task automatic issue(input logic [FUNC_W-1:0] f, input logic [DATA_W-1:0] v,
		input logic [POS_W-1:0] p);
		req_t r;
		r.func = f;
		r.value = v;
		r.position = p;
		req_pending_q.push_back(r);
		while (req_pending_q.size() != 0) @(posedge clk);
	endtask

	// driver: hold the request until accepted, then idle for a random gap
	always @(posedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			if (start && !busy) begin
				apply_request(req);
				req_pending_q.delete(0);
				accepted_n++;
				gap_left = pick_gap();
			end
			if (start && busy) begin
				// hold the request until the block takes it
			end else if (gap_left > 0) begin
				gap_left--;
				start <= 1'b0;
			end else if (req_pending_q.size() > 0) begin
				start <= 1'b1;
				req <= req_pending_q[0];
			end else begin
				start <= 1'b0;
			end
		end
	end

	// monitor: compare every strobed result with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && strobe) begin
			if (dump_expect_q.size() == 0) begin
				err_n++;
				$display("%0t: unexpected result element=%0d last=%0b empty=%0b rej=%0b",
					$time, res.element, res.last, res.empty_res, res.rejected);
			end else begin
				exp_r = dump_expect_q.pop_front();
				checked_n++;
				if (res.element !== exp_r.element || res.last !== exp_r.last ||
					res.empty_res !== exp_r.empty_res ||
					res.rejected !== exp_r.rejected) begin
					err_n++;
					$display("%0t: mismatch expected element=%0d last=%0b empty=%0b rej=%0b, actual element=%0d last=%0b empty=%0b rej=%0b",
						$time, exp_r.element, exp_r.last, exp_r.empty_res,
						exp_r.rejected, res.element, res.last, res.empty_res,
						res.rejected);
				end
			end
		end
	end

	// stimulus: directed corner cases, then a fill to capacity, then a mixed drain
	initial begin
		int full_tries;
		full_tries = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty store: remove and unused code both dump the empty result
		issue(FUNC_REMOVE, 32'h0000_0000, 8'd0);
		issue(FUNC_UNUSED, 32'hFFFF_FFFF, 8'hFF);
		// extremes of value through both insert kinds
		issue(FUNC_PUSH_FRONT, 32'h8000_0000, 8'h00);
		issue(FUNC_APPEND, 32'h7FFF_FFFF, 8'hFF);
		issue(FUNC_PUSH_FRONT, 32'hFFFF_FFFF, 8'h80);
		issue(FUNC_APPEND, 32'h0000_0000, 8'h7F);
		// out-of-range removes are ignored
		issue(FUNC_REMOVE, 32'hFFFF_FFFF, 8'd255);
		issue(FUNC_REMOVE, 32'h1234_5678, 8'd4);
		issue(FUNC_UNUSED, $urandom, POS_W'($urandom));
		// remove from middle, back and front down to empty
		issue(FUNC_REMOVE, 32'h0, 8'd1);
		issue(FUNC_REMOVE, 32'h0, 8'd2);
		issue(FUNC_REMOVE, 32'h0, 8'd0);
		issue(FUNC_REMOVE, 32'h0, 8'd0);
		issue(FUNC_REMOVE, 32'h0, 8'd0);
		issue(FUNC_APPEND, 32'h5555_5555, 8'h55);
		issue(FUNC_PUSH_FRONT, 32'hAAAA_AAAA, 8'hAA);

		// grow to capacity, then keep pushing so inserts get dropped
		while (seq_model.size() < CAPACITY || full_tries < 6) begin
			if (seq_model.size() == CAPACITY)
				full_tries++;
			req_pending_q.push_back(random_request(90));
			while (req_pending_q.size() != 0) @(posedge clk);
		end
		// remove-heavy mix
		repeat (15) begin
			req_pending_q.push_back(random_request(30));
			while (req_pending_q.size() != 0) @(posedge clk);
		end

		while (dump_expect_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Ran %0d requests, checked %0d results; %0d inserts dropped when full,",
			accepted_n, checked_n, reject_n);
		$display("peak depth %0d of %0d, %0d errors", peak_depth, CAPACITY, err_n);
		if (err_n == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// watchdog
	initial begin
		#2_000_000;
		$display("Timeout with %0d results still expected", dump_expect_q.size());
		$display("simulation failed");
		$finish;
	end

endmodule
